FILE: rtl/ntc_thermistor_temperature_unit_defines.svh
// Assertion macros used by the checker of the thermistor unit.
`ifndef NTC_THERMISTOR_TEMPERATURE_UNIT_DEFINES_SVH
`define NTC_THERMISTOR_TEMPERATURE_UNIT_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define NTC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("thermistor unit check failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("thermistor unit check failed");

`endif

FILE: rtl/ntc_pkg.sv
// Shared widths, constants and types of the thermistor temperature unit.
package ntc_pkg;
   localparam int ADC_BITS_DEFAULT = 12;
   localparam int RES_W            = 20;
   localparam int BETA_W           = 14;
   localparam int TREF_W           = 16;
   localparam int TEMP_W           = 15;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 20;

   localparam int LOG_FRAC_BITS    = 24;
   localparam int LOG_INT_BITS     = 5;
   localparam int LOG_W            = LOG_INT_BITS + LOG_FRAC_BITS;
   localparam int MANT_W           = 32;
   localparam int LSUM_W           = 31;
   localparam int PROD_W           = 55;
   localparam int Y_W              = 57;
   localparam int TCK_W            = 56;

   localparam logic [23:0]       LN2_Q24   = 24'hB17218;
   localparam logic [PROD_W-1:0] SCALE_Q48 = PROD_W'(100) << 48;

   localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 15'sd15000;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -15'sd5500;
   localparam int ZERO_C_CK = 27315;
   localparam int TCK_HIGH  = 42315;
   localparam int TCK_LOW   = 21815;

   localparam logic [RES_W-1:0]  SERIES_RES_RESET  = 20'd18000;
   localparam logic [RES_W-1:0]  NOMINAL_RES_RESET = 20'd10000;
   localparam logic [BETA_W-1:0] BETA_RESET        = 14'd3977;
   localparam logic [TREF_W-1:0] REF_TEMP_RESET    = 16'd29815;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SERIES_RES  = 3'd0,
      CSR_NOMINAL_RES = 3'd1,
      CSR_BETA        = 3'd2,
      CSR_REF_TEMP    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic code_zero;
      logic p_negative;
   } div_a_side_type;

   typedef struct packed {
      logic code_zero;
      logic y_nonpos;
   } div_b_side_type;
endpackage

FILE: rtl/ntc_if.sv
// Channel interfaces of the thermistor unit: request, response and register write.
interface ntc_req_if import ntc_pkg::*; #(parameter int ADC_BITS = ADC_BITS_DEFAULT);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_code;
   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntc_rsp_if import ntc_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi_c;
   logic                     range_flag;
   modport source (output valid, output temperature_centi_c, output range_flag, input ready);
   modport sink   (input valid, input temperature_centi_c, input range_flag, output ready);
endinterface

interface ntc_csr_if import ntc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  write_data;
   modport source (output valid, output index, output write_data, input ready);
   modport sink   (input valid, input index, input write_data, output ready);
endinterface

FILE: rtl/ntc_thermistor_temperature_unit.sv
// Top level of the thermistor temperature unit: registers, datapath stages and output skid.
//
//   channel  direction  payload                              transfer when
//   req_ch   in         adc_code                             valid && ready
//   rsp_ch   out        temperature_centi_c, range_flag      valid && ready
//   csr_ch   in         index, write_data                    valid && ready (always ready)
//
// One code enters per cycle while the pipeline is not halted; a result passes through
// 25 log stages, 2 sum and multiply stages, 55 stages of the first divider pair,
// 2 stages to form the reciprocal temperature, 56 stages of the final divider,
// one saturation stage and the output register.
// Reset is synchronous and empties the pipeline and restores the register defaults.
// A waiting result moves into a skid register; the pipeline halts only while that is full.
module ntc_thermistor_temperature_unit import ntc_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   ntc_req_if.sink     req_ch,
   ntc_rsp_if.source   rsp_ch,
   ntc_csr_if.sink     csr_ch
);
   logic [RES_W-1:0]  series_ff;
   logic [RES_W-1:0]  nominal_ff;
   logic [BETA_W-1:0] beta_ff;
   logic [TREF_W-1:0] tref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= SERIES_RES_RESET;
         nominal_ff <= NOMINAL_RES_RESET;
         beta_ff    <= BETA_RESET;
         tref_ff    <= REF_TEMP_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_SERIES_RES:  series_ff  <= csr_ch.write_data[RES_W-1:0];
            CSR_NOMINAL_RES: nominal_ff <= csr_ch.write_data[RES_W-1:0];
            CSR_BETA:        beta_ff    <= csr_ch.write_data[BETA_W-1:0];
            CSR_REF_TEMP:    tref_ff    <= csr_ch.write_data[TREF_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   logic pipe_en;
   logic skid_valid_ff;
   assign pipe_en      = !skid_valid_ff;
   assign req_ch.ready = pipe_en;

   // Log stage inputs: both resistors, the code and its complement to full scale.
   logic [ADC_BITS-1:0]         code;
   logic [ADC_BITS-1:0]         comp;
   logic [3:0][RES_W-1:0]       log_n;
   logic                        log_valid;
   logic [3:0][LOG_W-1:0]       log_out;
   logic                        log_zero;

   assign code     = ADC_BITS'(req_ch.adc_code);
   assign comp     = -code;
   assign log_n[0] = series_ff;
   assign log_n[1] = RES_W'(code);
   assign log_n[2] = RES_W'(comp);
   assign log_n[3] = nominal_ff;

   ntc_log2_pipe #(.LANES(4), .SIDE_W(1)) u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_ch.valid),
      .in_n      (log_n),
      .in_side   (code == '0),
      .out_valid (log_valid),
      .out_log   (log_out),
      .out_side  (log_zero)
   );

   logic                     lsum_valid_ff;
   logic                     lsum_zero_ff;
   logic [LSUM_W-1:0]        lsum_ff;
   logic [LSUM_W-1:0]        lsum_in;
   logic                     prod_valid_ff;
   div_a_side_type           prod_side_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [LSUM_W-1:0]        lmag;

   assign lsum_in = LSUM_W'(log_out[0]) + LSUM_W'(log_out[1])
                  - LSUM_W'(log_out[2]) - LSUM_W'(log_out[3]);
   assign lmag    = lsum_ff[LSUM_W-1] ? -lsum_ff : lsum_ff;

   // First division lanes: the log term by beta, and the scale by the reference temperature.
   logic [BETA_W-1:0]            beta_eff;
   logic [TREF_W-1:0]            tref_eff;
   logic [1:0][PROD_W-1:0]       diva_num;
   logic [1:0][TREF_W-1:0]       diva_den;
   logic                         diva_valid;
   logic [1:0][PROD_W-1:0]       diva_quo;
   div_a_side_type               diva_side;

   assign beta_eff    = (beta_ff == '0) ? BETA_W'(1) : beta_ff;
   assign tref_eff    = (tref_ff == '0) ? TREF_W'(1) : tref_ff;
   assign diva_num[0] = prod_ff;
   assign diva_num[1] = SCALE_Q48;
   assign diva_den[0] = TREF_W'(beta_eff);
   assign diva_den[1] = tref_eff;

   ntc_div_pipe #(.LANES(2), .NUM_W(PROD_W), .DEN_W(TREF_W),
                  .SIDE_W($bits(div_a_side_type))) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (prod_valid_ff),
      .in_num    (diva_num),
      .in_den    (diva_den),
      .in_side   (prod_side_ff),
      .out_valid (diva_valid),
      .out_quo   (diva_quo),
      .out_side  (diva_side)
   );

   logic                 y_valid_ff;
   logic                 y_zero_ff;
   logic [Y_W-1:0]       y_ff;
   logic [Y_W-1:0]       y_in;
   logic                 dd_valid_ff;
   div_b_side_type       dd_side_ff;
   logic [TCK_W-1:0]     dd_num_ff;
   logic [TCK_W-1:0]     dd_den_ff;
   logic                 y_nonpos;

   assign y_in = diva_side.p_negative ? (Y_W'(diva_quo[1]) - Y_W'(diva_quo[0]))
                                      : (Y_W'(diva_quo[1]) + Y_W'(diva_quo[0]));
   assign y_nonpos = y_ff[Y_W-1] || (y_ff == '0);

   logic                 divb_valid;
   logic [0:0][TCK_W-1:0] divb_quo;
   div_b_side_type       divb_side;

   ntc_div_pipe #(.LANES(1), .NUM_W(TCK_W), .DEN_W(TCK_W),
                  .SIDE_W($bits(div_b_side_type))) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (dd_valid_ff),
      .in_num    (dd_num_ff),
      .in_den    (dd_den_ff),
      .in_side   (dd_side_ff),
      .out_valid (divb_valid),
      .out_quo   (divb_quo),
      .out_side  (divb_side)
   );

   logic                     fin_valid_ff;
   logic signed [TEMP_W-1:0] fin_temp_ff;
   logic                     fin_flag_ff;
   logic signed [TEMP_W-1:0] fin_temp_in;
   logic                     fin_flag_in;
   logic [TCK_W-1:0]         tck;

   assign tck = divb_quo[0];

   always_comb begin
      fin_flag_in = 1'b1;
      priority if (divb_side.code_zero || series_ff == '0) begin
         fin_temp_in = TEMP_HIGH;
      end else if (nominal_ff == '0) begin
         fin_temp_in = TEMP_LOW;
      end else if (divb_side.y_nonpos) begin
         fin_temp_in = TEMP_HIGH;
      end else if (tck > TCK_W'(TCK_HIGH)) begin
         fin_temp_in = TEMP_HIGH;
      end else if (tck < TCK_W'(TCK_LOW)) begin
         fin_temp_in = TEMP_LOW;
      end else begin
         fin_temp_in = TEMP_W'(tck - TCK_W'(ZERO_C_CK));
         fin_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lsum_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         y_valid_ff    <= 1'b0;
         dd_valid_ff   <= 1'b0;
         fin_valid_ff  <= 1'b0;
      end else if (pipe_en) begin
         lsum_valid_ff <= log_valid;
         prod_valid_ff <= lsum_valid_ff;
         y_valid_ff    <= diva_valid;
         dd_valid_ff   <= y_valid_ff;
         fin_valid_ff  <= divb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lsum_ff                 <= lsum_in;
         lsum_zero_ff            <= log_zero;
         prod_ff                 <= PROD_W'(lmag) * PROD_W'(LN2_Q24);
         prod_side_ff.code_zero  <= lsum_zero_ff;
         prod_side_ff.p_negative <= lsum_ff[LSUM_W-1];
         y_ff                    <= y_in;
         y_zero_ff               <= diva_side.code_zero;
         // The final dividend rounds to nearest by adding half the divisor.
         dd_num_ff               <= TCK_W'(SCALE_Q48) + TCK_W'(y_ff >> 1);
         dd_den_ff               <= y_nonpos ? TCK_W'(1) : y_ff[TCK_W-1:0];
         dd_side_ff.code_zero    <= y_zero_ff;
         dd_side_ff.y_nonpos     <= y_nonpos;
         fin_temp_ff             <= fin_temp_in;
         fin_flag_ff             <= fin_flag_in;
      end
   end

   // Output register with a skid register behind it.
   logic                     out_valid_ff;
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic                     out_flag_ff;
   logic signed [TEMP_W-1:0] skid_temp_ff;
   logic                     skid_flag_ff;
   logic                     out_valid_in;
   logic                     skid_valid_in;
   logic                     take;
   logic                     push;
   logic                     out_load;
   logic                     out_from_skid;
   logic                     skid_load;

   always_comb begin
      take          = out_valid_ff && rsp_ch.ready;
      push          = pipe_en && fin_valid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      out_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (take) begin
            out_load      = 1'b1;
            out_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_load     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_temp_ff <= out_from_skid ? skid_temp_ff : fin_temp_ff;
         out_flag_ff <= out_from_skid ? skid_flag_ff : fin_flag_ff;
      end
      if (skid_load) begin
         skid_temp_ff <= fin_temp_ff;
         skid_flag_ff <= fin_flag_ff;
      end
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.temperature_centi_c = out_temp_ff;
   assign rsp_ch.range_flag          = out_flag_ff;
endmodule

FILE: rtl/ntc_log2_pipe.sv
// Pipelined base-2 logarithm in Q24, several lanes, one fraction bit per stage.
module ntc_log2_pipe import ntc_pkg::*; #(
   parameter int LANES  = 4,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [LANES-1:0][RES_W-1:0]       in_n,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [LANES-1:0][LOG_W-1:0]       out_log,
   output logic [SIDE_W-1:0]                 out_side
);
   localparam int STAGES = LOG_FRAC_BITS + 1;

   logic [STAGES-1:0]                        valid_ff;
   logic [SIDE_W-1:0]                        side_ff  [STAGES];
   logic [LANES-1:0][LOG_INT_BITS-1:0]       exp_ff   [STAGES];
   logic [LANES-1:0][MANT_W-1:0]             mant_ff  [STAGES];
   logic [LANES-1:0][LOG_FRAC_BITS-1:0]      frac_ff  [STAGES];
   logic [LANES-1:0][LOG_INT_BITS-1:0]       exp_in   [STAGES];
   logic [LANES-1:0][MANT_W-1:0]             mant_in  [STAGES];
   logic [LANES-1:0][LOG_FRAC_BITS-1:0]      frac_in  [STAGES];

   always_comb begin
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W-1:0]   m;
      sq = '0;
      m  = '0;
      // First stage: integer part from the leading one, mantissa normalized to Q31.
      for (int l = 0; l < LANES; l++) begin
         exp_in[0][l] = '0;
         for (int b = 1; b < RES_W; b++) begin
            if (in_n[l][b]) begin
               exp_in[0][l] = LOG_INT_BITS'(b);
            end
         end
         mant_in[0][l] = MANT_W'(in_n[l]) << (LOG_INT_BITS'(MANT_W - 1) - exp_in[0][l]);
         frac_in[0][l] = '0;
      end
      // Each later stage squares the mantissa and yields one fraction bit.
      for (int s = 1; s < STAGES; s++) begin
         for (int l = 0; l < LANES; l++) begin
            m  = mant_ff[s-1][l];
            sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
            exp_in[s][l] = exp_ff[s-1][l];
            if (sq[2*MANT_W-1]) begin
               mant_in[s][l] = sq[2*MANT_W-1 -: MANT_W];
               frac_in[s][l] = {frac_ff[s-1][l][LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
               mant_in[s][l] = sq[2*MANT_W-2 -: MANT_W];
               frac_in[s][l] = {frac_ff[s-1][l][LOG_FRAC_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp_ff     <= exp_in;
         mant_ff    <= mant_in;
         frac_ff    <= frac_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_log[l] = {exp_ff[STAGES-1][l], frac_ff[STAGES-1][l]};
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
endmodule

FILE: rtl/ntc_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, several lanes.
module ntc_div_pipe import ntc_pkg::*; #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 56,
   parameter int DEN_W  = 56,
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [LANES-1:0][DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][NUM_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]             out_side
);
   logic [NUM_W-1:0]                valid_ff;
   logic [SIDE_W-1:0]               side_ff [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     rem_ff  [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     num_ff  [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     quo_ff  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     den_ff  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     rem_in  [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     num_in  [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]     quo_in  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]     den_in  [NUM_W];

   always_comb begin
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] rem_pv;
      logic [NUM_W-1:0] num_pv;
      logic [NUM_W-1:0] quo_pv;
      logic [DEN_W-1:0] den_pv;
      trial = '0;
      for (int s = 0; s < NUM_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            if (s == 0) begin
               rem_pv = '0;
               num_pv = in_num[l];
               quo_pv = '0;
               den_pv = in_den[l];
            end else begin
               rem_pv = rem_ff[s-1][l];
               num_pv = num_ff[s-1][l];
               quo_pv = quo_ff[s-1][l];
               den_pv = den_ff[s-1][l];
            end
            trial = {rem_pv, num_pv[NUM_W-1]};
            if (trial >= {1'b0, den_pv}) begin
               rem_in[s][l] = DEN_W'(trial - {1'b0, den_pv});
               quo_in[s][l] = {quo_pv[NUM_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = trial[DEN_W-1:0];
               quo_in[s][l] = {quo_pv[NUM_W-2:0], 1'b0};
            end
            num_in[s][l] = {num_pv[NUM_W-2:0], 1'b0};
            den_in[s][l] = den_pv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff     <= rem_in;
         num_ff     <= num_in;
         quo_ff     <= quo_in;
         den_ff     <= den_in;
         side_ff[0] <= in_side;
         for (int s = 1; s < NUM_W; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule

FILE: rtl/ntc_checker.sv
// Port-level checks of the thermistor unit and their binding to the top level.
`include "ntc_thermistor_temperature_unit_defines.svh"

module ntc_checker import ntc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] rsp_temp,
   input logic                     rsp_flag
);
   // A result that is not taken stays put.
   `NTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_temp) && $stable(rsp_flag))

   // A raised range flag always comes with one of the two saturation values.
   `NTC_ASSERT_IMP(a_flag_bound, clock, reset, rsp_valid && rsp_flag, rsp_temp == TEMP_HIGH || rsp_temp == TEMP_LOW)

   // Without the flag the temperature lies inside the output range.
   `NTC_ASSERT_IMP(a_in_range, clock, reset, rsp_valid && !rsp_flag, rsp_temp <= TEMP_HIGH && rsp_temp >= TEMP_LOW)

   // Reset empties the output side.
   `NTC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
endmodule

bind ntc_thermistor_temperature_unit ntc_checker u_ntc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_temp  (rsp_ch.temperature_centi_c),
   .rsp_flag  (rsp_ch.range_flag)
);
